>>> hdl/assert_macros.svh
// Assertion macros used by the top level of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/sicf_pkg.sv
// Types, constants and the arctangent table of the shape index filter.
`default_nettype none

package sicf_pkg;

   localparam int K_WIDTH          = 32;
   localparam int CORDIC_WIDTH     = 36;
   localparam int ANGLE_WIDTH      = 27;
   localparam int SI_WIDTH         = 16;
   localparam int GC_WIDTH         = 64;
   localparam int INDEX_WIDTH      = 20;
   localparam int CSR_DATA_WIDTH   = 64;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int ROUND_BIAS       = 256;
   localparam int ROUND_SHIFT      = 9;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SI_MIN = 2'd0,
      CSR_SI_MAX = 2'd1,
      CSR_GC_MIN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [K_WIDTH-1:0] max_curvature;
      logic signed [K_WIDTH-1:0] min_curvature;
      logic [INDEX_WIDTH-1:0]    point_index;
   } req_type;

   typedef struct packed {
      logic signed [SI_WIDTH-1:0] shape_index;
      logic signed [GC_WIDTH-1:0] gaussian_curvature;
      logic                       defined;
      logic                       keep;
      logic [INDEX_WIDTH-1:0]     echoed_index;
   } rsp_type;

   // Values that ride alongside the CORDIC vector through the pipeline.
   typedef struct packed {
      logic                       defined;
      logic                       x_zero;
      logic                       y_zero;
      logic                       y_positive;
      logic signed [GC_WIDTH-1:0] gc;
      logic [INDEX_WIDTH-1:0]     index;
   } side_type;

   // atan(2^-i) in quarter turns scaled by 2^24, rounded.
   function automatic logic signed [ANGLE_WIDTH-1:0] atan_step(input int step);
      logic signed [ANGLE_WIDTH-1:0] value;
      case (step)
         0:       value = ANGLE_WIDTH'(8388608);
         1:       value = ANGLE_WIDTH'(4952084);
         2:       value = ANGLE_WIDTH'(2616545);
         3:       value = ANGLE_WIDTH'(1328199);
         4:       value = ANGLE_WIDTH'(666677);
         5:       value = ANGLE_WIDTH'(333664);
         6:       value = ANGLE_WIDTH'(166872);
         7:       value = ANGLE_WIDTH'(83441);
         8:       value = ANGLE_WIDTH'(41721);
         9:       value = ANGLE_WIDTH'(20861);
         10:      value = ANGLE_WIDTH'(10430);
         11:      value = ANGLE_WIDTH'(5215);
         12:      value = ANGLE_WIDTH'(2608);
         13:      value = ANGLE_WIDTH'(1304);
         14:      value = ANGLE_WIDTH'(652);
         15:      value = ANGLE_WIDTH'(326);
         16:      value = ANGLE_WIDTH'(163);
         17:      value = ANGLE_WIDTH'(81);
         18:      value = ANGLE_WIDTH'(41);
         19:      value = ANGLE_WIDTH'(20);
         20:      value = ANGLE_WIDTH'(10);
         21:      value = ANGLE_WIDTH'(5);
         22:      value = ANGLE_WIDTH'(3);
         23:      value = ANGLE_WIDTH'(1);
         24:      value = ANGLE_WIDTH'(1);
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

>>> hdl/shape_index_curvature_filter_core.sv
// Top level of the shape index and Gaussian curvature filter.
//
//   port group   direction  handshake
//   req_         in         start, taken when busy is low
//   rsp_         out        rsp_strobe, one cycle, no back pressure
//   csr_         in         csr_write_enable, written at once
//
// One request can be taken in every cycle while busy is low. The request edge
// loads the input register; the result then passes one setup stage, one stage
// per CORDIC iteration and two output stages before it is on rsp_data.
// Reset is synchronous; busy is high while reset is held.
// The result side never stalls, so the pipeline always advances.
`default_nettype none
`include "assert_macros.svh"

module shape_index_curvature_filter_core #(
   parameter int CORDIC_STEPS = 16,
   parameter int INDEX_BITS   = 20
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire sicf_pkg::req_type                      req_data,
   output logic                                        rsp_strobe,
   output sicf_pkg::rsp_type                           rsp_data,
   input  wire logic                                   csr_write_enable,
   input  wire logic [sicf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [sicf_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   localparam int LATENCY = CORDIC_STEPS + 3;

   logic signed [sicf_pkg::SI_WIDTH-1:0] si_min_ff;
   logic signed [sicf_pkg::SI_WIDTH-1:0] si_max_ff;
   logic signed [sicf_pkg::GC_WIDTH-1:0] gc_min_ff;

   logic                                     accept;
   logic                                     valid_pipe [CORDIC_STEPS+1];
   logic signed [sicf_pkg::CORDIC_WIDTH-1:0] x_pipe     [CORDIC_STEPS+1];
   logic signed [sicf_pkg::CORDIC_WIDTH-1:0] y_pipe     [CORDIC_STEPS+1];
   logic signed [sicf_pkg::ANGLE_WIDTH-1:0]  z_pipe     [CORDIC_STEPS+1];
   sicf_pkg::side_type                       side_pipe  [CORDIC_STEPS+1];

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         si_min_ff <= 16'sh8000;
         si_max_ff <= 16'sh7FFF;
         gc_min_ff <= {1'b1, {(sicf_pkg::GC_WIDTH-1){1'b0}}};
      end else if (csr_write_enable) begin
         case (sicf_pkg::csr_index_type'(csr_index))
            sicf_pkg::CSR_SI_MIN: si_min_ff <= csr_write_data[sicf_pkg::SI_WIDTH-1:0];
            sicf_pkg::CSR_SI_MAX: si_max_ff <= csr_write_data[sicf_pkg::SI_WIDTH-1:0];
            sicf_pkg::CSR_GC_MIN: gc_min_ff <= csr_write_data[sicf_pkg::GC_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   sicf_front #(
      .INDEX_BITS(INDEX_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_data),
      .out_valid (valid_pipe[0]),
      .out_x     (x_pipe[0]),
      .out_y     (y_pipe[0]),
      .out_side  (side_pipe[0])
   );

   assign z_pipe[0] = '0;

   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_stage
      sicf_cordic_stage #(
         .STEP(s)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_pipe[s]),
         .in_x      (x_pipe[s]),
         .in_y      (y_pipe[s]),
         .in_z      (z_pipe[s]),
         .in_side   (side_pipe[s]),
         .out_valid (valid_pipe[s+1]),
         .out_x     (x_pipe[s+1]),
         .out_y     (y_pipe[s+1]),
         .out_z     (z_pipe[s+1]),
         .out_side  (side_pipe[s+1])
      );
   end

   sicf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_pipe[CORDIC_STEPS]),
      .in_z      (z_pipe[CORDIC_STEPS]),
      .in_side   (side_pipe[CORDIC_STEPS]),
      .si_min    (si_min_ff),
      .si_max    (si_max_ff),
      .gc_min    (gc_min_ff),
      .out_valid (rsp_strobe),
      .out_rsp   (rsp_data)
   );

   // A kept point always has a defined shape index.
   `ASSERT_SAME_CYCLE(a_keep_defined, clock, reset, rsp_strobe && rsp_data.keep, rsp_data.defined)

   // An undefined point carries a zero index and a zero product.
   `ASSERT_SAME_CYCLE(a_undef_zero, clock, reset, rsp_strobe && !rsp_data.defined, (rsp_data.shape_index == '0) && (rsp_data.gaussian_curvature == '0))

   // Each result strobe traces back through every pipeline register to an accepted request.
   `ASSERT_SAME_CYCLE(a_latency, clock, reset, rsp_strobe, $past(accept, LATENCY + 1))

   // The front stage holds a valid request in the cycle after it is taken.
   `ASSERT_NEXT_CYCLE(a_front_fill, clock, reset, accept, u_front.valid_ff)

endmodule

`default_nettype wire

>>> hdl/sicf_front.sv
// Input register, vector setup and Gaussian curvature multiply.
`default_nettype none

module sicf_front #(
   parameter int INDEX_BITS = 20
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        in_valid,
   input  wire sicf_pkg::req_type                           in_req,
   output logic                                             out_valid,
   output logic signed [sicf_pkg::CORDIC_WIDTH-1:0]         out_x,
   output logic signed [sicf_pkg::CORDIC_WIDTH-1:0]         out_y,
   output sicf_pkg::side_type                               out_side
);

   localparam int SUM_WIDTH = sicf_pkg::K_WIDTH + 1;

   logic              valid_ff;
   sicf_pkg::req_type req_ff;

   logic                                     valid2_ff;
   logic signed [sicf_pkg::CORDIC_WIDTH-1:0] x_ff, x_in;
   logic signed [sicf_pkg::CORDIC_WIDTH-1:0] y_ff, y_in;
   sicf_pkg::side_type                       side_ff, side_in;

   logic signed [SUM_WIDTH-1:0] diff;
   logic signed [SUM_WIDTH-1:0] sum;
   logic [SUM_WIDTH-1:0]        abs_diff;
   logic [sicf_pkg::INDEX_WIDTH-1:0] index_masked;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid_ff  <= in_valid;
         valid2_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= in_req;
      x_ff    <= x_in;
      y_ff    <= y_in;
      side_ff <= side_in;
   end

   always_comb begin
      diff = SUM_WIDTH'(req_ff.max_curvature) - SUM_WIDTH'(req_ff.min_curvature);
      sum  = SUM_WIDTH'(req_ff.max_curvature) + SUM_WIDTH'(req_ff.min_curvature);
      abs_diff = diff[SUM_WIDTH-1] ? SUM_WIDTH'(-diff) : SUM_WIDTH'(diff);
      for (int b = 0; b < sicf_pkg::INDEX_WIDTH; b++) begin
         index_masked[b] = req_ff.point_index[b] & (b < INDEX_BITS);
      end
      x_in = sicf_pkg::CORDIC_WIDTH'($signed({1'b0, abs_diff}));
      y_in = sicf_pkg::CORDIC_WIDTH'(sum);
      side_in.defined    = (|req_ff.max_curvature) | (|req_ff.min_curvature);
      side_in.x_zero     = (req_ff.max_curvature == req_ff.min_curvature);
      side_in.y_zero     = (sum == '0);
      side_in.y_positive = !sum[SUM_WIDTH-1] && (sum != '0);
      side_in.gc         = req_ff.max_curvature * req_ff.min_curvature;
      side_in.index      = index_masked;
   end

   assign out_valid = valid2_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

>>> hdl/sicf_cordic_stage.sv
// One registered vectoring step of the arctangent CORDIC.
`default_nettype none

module sicf_cordic_stage #(
   parameter int STEP = 0
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       in_valid,
   input  wire logic signed [sicf_pkg::CORDIC_WIDTH-1:0]   in_x,
   input  wire logic signed [sicf_pkg::CORDIC_WIDTH-1:0]   in_y,
   input  wire logic signed [sicf_pkg::ANGLE_WIDTH-1:0]    in_z,
   input  wire sicf_pkg::side_type                         in_side,
   output logic                                            out_valid,
   output logic signed [sicf_pkg::CORDIC_WIDTH-1:0]        out_x,
   output logic signed [sicf_pkg::CORDIC_WIDTH-1:0]        out_y,
   output logic signed [sicf_pkg::ANGLE_WIDTH-1:0]         out_z,
   output sicf_pkg::side_type                              out_side
);

   localparam logic signed [sicf_pkg::ANGLE_WIDTH-1:0] ANGLE = sicf_pkg::atan_step(STEP);

   logic                                     valid_ff;
   logic signed [sicf_pkg::CORDIC_WIDTH-1:0] x_ff, x_in;
   logic signed [sicf_pkg::CORDIC_WIDTH-1:0] y_ff, y_in;
   logic signed [sicf_pkg::ANGLE_WIDTH-1:0]  z_ff, z_in;
   sicf_pkg::side_type                       side_ff;
   logic signed [sicf_pkg::CORDIC_WIDTH-1:0] dx, dy;

   always_comb begin
      // Arithmetic shifts round toward minus infinity.
      dx = in_y >>> STEP;
      dy = in_x >>> STEP;
      if (!in_y[sicf_pkg::CORDIC_WIDTH-1]) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ANGLE;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

>>> hdl/sicf_back.sv
// Rounding, saturation, special cases and threshold tests.
`default_nettype none

module sicf_back (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     in_valid,
   input  wire logic signed [sicf_pkg::ANGLE_WIDTH-1:0]  in_z,
   input  wire sicf_pkg::side_type                       in_side,
   input  wire logic signed [sicf_pkg::SI_WIDTH-1:0]     si_min,
   input  wire logic signed [sicf_pkg::SI_WIDTH-1:0]     si_max,
   input  wire logic signed [sicf_pkg::GC_WIDTH-1:0]     gc_min,
   output logic                                          out_valid,
   output sicf_pkg::rsp_type                             out_rsp
);

   localparam int RW = sicf_pkg::ANGLE_WIDTH + 1;
   localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
   localparam logic signed [RW-1:0] SAT_LO = RW'(-32768);
   localparam logic signed [sicf_pkg::SI_WIDTH-1:0] SI_PLUS_ONE  = 16'sh7FFF;
   localparam logic signed [sicf_pkg::SI_WIDTH-1:0] SI_MINUS_ONE = 16'sh8000;

   logic signed [RW-1:0] biased;
   logic signed [RW-1:0] rounded;
   logic signed [sicf_pkg::SI_WIDTH-1:0] si_in;
   logic signed [sicf_pkg::SI_WIDTH-1:0] si_ff;
   logic                                 gc_above_in, gc_above_ff;
   logic                                 valid1_ff;
   sicf_pkg::side_type                   side_ff;

   logic              valid2_ff;
   sicf_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      biased  = RW'(sicf_pkg::ROUND_BIAS) - RW'(in_z);
      rounded = biased >>> sicf_pkg::ROUND_SHIFT;
      if (!in_side.defined) begin
         si_in = '0;
      end else if (in_side.x_zero) begin
         si_in = in_side.y_positive ? SI_MINUS_ONE : SI_PLUS_ONE;
      end else if (in_side.y_zero) begin
         si_in = '0;
      end else if (rounded > SAT_HI) begin
         si_in = SI_PLUS_ONE;
      end else if (rounded < SAT_LO) begin
         si_in = SI_MINUS_ONE;
      end else begin
         si_in = rounded[sicf_pkg::SI_WIDTH-1:0];
      end
      gc_above_in = (in_side.gc > gc_min);
   end

   always_comb begin
      rsp_in.shape_index        = si_ff;
      rsp_in.gaussian_curvature = side_ff.gc;
      rsp_in.defined            = side_ff.defined;
      rsp_in.keep               = side_ff.defined && gc_above_ff
                                  && (si_ff > si_min) && (si_ff < si_max);
      rsp_in.echoed_index       = side_ff.index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      gc_above_ff <= gc_above_in;
      side_ff     <= in_side;
      rsp_ff      <= rsp_in;
   end

   assign out_valid = valid2_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire
